// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the tracker RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on a given clock with a synchronous active-low reset
`define GIOU_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property on the block clock and reset
`define GIOU_ASSERT_TOP(lbl, prop, msg) \
    `GIOU_ASSERT(lbl, i_clk, i_rst_n, prop, msg)

`endif

// ----- rtl/giou_pkg.sv -----
// Shared constants, types and helpers of the greedy IoU track association block
package giou_pkg;

    localparam int MAX_TRACKS = 32;
    localparam int COORD_BITS = 16;
    localparam int SLOT_W     = $clog2(MAX_TRACKS);
    localparam int FIELD_W    = 16;
    localparam int SPAN_W     = COORD_BITS;
    localparam int AREA_W     = 2 * COORD_BITS;
    localparam int UNION_W    = AREA_W + 1;
    localparam int PROD_W     = AREA_W + UNION_W;
    localparam int THR_W      = 11;
    localparam int LOST_W     = 16;
    localparam int ID_W       = 32;
    localparam int FRAME_W    = 32;
    localparam int THR_PROD_W = THR_W + UNION_W;
    localparam int IOU_SHIFT  = 10;
    localparam int IN_DATA_W  = 4 * FIELD_W + FRAME_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_MATCH_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOST_LIMIT      = 1'd1;

    localparam logic [THR_W-1:0]  THR_RESET  = 11'd307;
    localparam logic [LOST_W-1:0] LOST_RESET = 16'd30;

    typedef struct packed {
        logic              load;
        logic              issue;
        logic [SLOT_W-1:0] addr;
        logic              thr;
        logic              commit;
        logic              sweep;
        logic              frame_start;
        logic              out_load;
    } t_cmd;

    typedef struct packed {
        logic frame_end;
        logic pipe_busy;
        logic out_free;
    } t_sts;

    function automatic logic [SPAN_W-1:0] span(input logic [SPAN_W-1:0] lo,
                                                input logic [SPAN_W-1:0] hi);
        return (hi > lo) ? (hi - lo) : '0;
    endfunction

endpackage

// ----- rtl/giou_dp.sv -----
// Datapath: track store, IoU scoring pipeline, best-match tracking and result register
module giou_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  giou_pkg::t_cmd                       i_cmd,
    output giou_pkg::t_sts                       o_sts,
    input  logic [giou_pkg::IN_DATA_W-1:0]       i_in_data,
    input  logic                                 i_in_end,
    input  logic                                 i_cfg_we,
    input  logic [giou_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [giou_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output logic                                 o_res_valid,
    output logic [giou_pkg::ID_W-1:0]            o_res_id,
    output logic [1:0]                           o_res_flags,
    input  logic                                 i_res_ready
);
    import giou_pkg::*;

    logic [THR_W-1:0]   r_thr;
    logic [LOST_W-1:0]  r_lost;

    logic [SPAN_W-1:0]  r_l, r_t, r_r, r_b;
    logic [FRAME_W-1:0] r_frame;
    logic               r_frame_end;

    logic [MAX_TRACKS-1:0] r_valid, r_pre, r_matched;
    logic [4*SPAN_W-1:0]      r_box_mem  [MAX_TRACKS];
    logic [ID_W+FRAME_W-1:0]  r_meta_mem [MAX_TRACKS];
    logic [4*SPAN_W-1:0]      r_box_q;
    logic [ID_W+FRAME_W-1:0]  r_meta_q;

    logic              r_s0_v, r_s1_v, r_s2_v, r_s3_v, r_sw_v;
    logic [SLOT_W-1:0] r_s0_slot, r_s1_slot, r_s2_slot, r_s3_slot, r_sw_slot;
    logic [ID_W-1:0]   r_s1_id, r_s2_id, r_s3_id;
    logic [AREA_W-1:0] r_s1_inter, r_s1_ad, r_s1_at, r_s2_inter;
    logic [UNION_W-1:0] r_s2_un;
    logic [PROD_W-1:0] r_s3_p1, r_s3_p2;
    logic [AREA_W-1:0] r_s3_inter;
    logic [UNION_W-1:0] r_s3_un;

    logic              r_found;
    logic [SLOT_W-1:0] r_best_slot;
    logic [ID_W-1:0]   r_best_id;
    logic [AREA_W-1:0] r_bi;
    logic [UNION_W-1:0] r_bu;
    logic [THR_PROD_W-1:0] r_thr_prod;
    logic [ID_W-1:0]   r_next_id;

    logic [ID_W-1:0]   r_res_id;
    logic              r_res_new, r_res_full;

    logic [SPAN_W-1:0] w_tl, w_tt, w_tr, w_tb, w_iw, w_ih;
    logic              w_better, w_match, w_free_any, w_we, w_stale;
    logic [SLOT_W-1:0] w_free_slot, w_waddr;
    logic [ID_W-1:0]   w_wid, w_inc_id;
    logic [FRAME_W-1:0] w_sw_last;

    assign w_tl = r_box_q[SPAN_W-1:0];
    assign w_tt = r_box_q[2*SPAN_W-1:SPAN_W];
    assign w_tr = r_box_q[3*SPAN_W-1:2*SPAN_W];
    assign w_tb = r_box_q[4*SPAN_W-1:3*SPAN_W];
    assign w_iw = span((r_l > w_tl) ? r_l : w_tl, (r_r < w_tr) ? r_r : w_tr);
    assign w_ih = span((r_t > w_tt) ? r_t : w_tt, (r_b < w_tb) ? r_b : w_tb);

    assign w_better = r_s3_v && (!r_found || (r_s3_p1 > r_s3_p2) ||
                      ((r_s3_p1 == r_s3_p2) && (r_s3_id < r_best_id)));
    assign w_match  = r_found && ((THR_PROD_W'(r_bi) << IOU_SHIFT) >= r_thr_prod);

    always_comb begin
        w_free_any  = 1'b0;
        w_free_slot = '0;
        for (int i = MAX_TRACKS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                w_free_any  = 1'b1;
                w_free_slot = SLOT_W'(i);
            end
        end
    end

    assign w_we     = i_cmd.commit && (w_match || w_free_any);
    assign w_waddr  = w_match ? r_best_slot : w_free_slot;
    assign w_wid    = w_match ? r_best_id : r_next_id;
    assign w_inc_id = r_next_id + 1'b1;

    assign w_sw_last = r_meta_q[ID_W+FRAME_W-1:ID_W];
    assign w_stale   = (r_frame > w_sw_last) &&
                       ((r_frame - w_sw_last) > FRAME_W'(r_lost));

    always_ff @(posedge i_clk) begin
        r_box_q  <= r_box_mem[i_cmd.addr];
        r_meta_q <= r_meta_mem[i_cmd.addr];
        if (w_we) begin
            r_box_mem[w_waddr]  <= {r_b, r_r, r_t, r_l};
            r_meta_mem[w_waddr] <= {r_frame, w_wid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_l         <= SPAN_W'(i_in_data[FIELD_W-1:0]);
            r_t         <= SPAN_W'(i_in_data[2*FIELD_W-1:FIELD_W]);
            r_r         <= SPAN_W'(i_in_data[3*FIELD_W-1:2*FIELD_W]);
            r_b         <= SPAN_W'(i_in_data[4*FIELD_W-1:3*FIELD_W]);
            r_frame     <= i_in_data[IN_DATA_W-1:4*FIELD_W];
            r_frame_end <= i_in_end;
        end
        r_s0_slot  <= i_cmd.addr;
        r_s1_slot  <= r_s0_slot;
        r_s1_id    <= r_meta_q[ID_W-1:0];
        r_s1_inter <= AREA_W'(w_iw) * AREA_W'(w_ih);
        r_s1_ad    <= AREA_W'(span(r_l, r_r)) * AREA_W'(span(r_t, r_b));
        r_s1_at    <= AREA_W'(span(w_tl, w_tr)) * AREA_W'(span(w_tt, w_tb));
        r_s2_slot  <= r_s1_slot;
        r_s2_id    <= r_s1_id;
        r_s2_inter <= r_s1_inter;
        r_s2_un    <= UNION_W'(r_s1_ad) + UNION_W'(r_s1_at) - UNION_W'(r_s1_inter);
        r_s3_slot  <= r_s2_slot;
        r_s3_id    <= r_s2_id;
        r_s3_inter <= r_s2_inter;
        r_s3_un    <= r_s2_un;
        r_s3_p1    <= PROD_W'(r_s2_inter) * PROD_W'(r_bu);
        r_s3_p2    <= PROD_W'(r_bi) * PROD_W'(r_s2_un);
        r_sw_slot  <= i_cmd.addr;
        if (i_cmd.thr) begin
            r_thr_prod <= THR_PROD_W'(r_thr) * THR_PROD_W'(r_bu);
        end
        if (i_cmd.commit) begin
            r_res_id   <= w_match ? r_best_id : (w_free_any ? r_next_id : '0);
            r_res_new  <= !w_match && w_free_any;
            r_res_full <= !w_match && !w_free_any;
        end
        if (i_cmd.load) begin
            r_bi <= '0;
            r_bu <= UNION_W'(1);
        end else if (w_better) begin
            r_bi        <= r_s3_inter;
            r_bu        <= r_s3_un;
            r_best_slot <= r_s3_slot;
            r_best_id   <= r_s3_id;
        end
        if (i_cmd.out_load) begin
            o_res_id    <= r_res_id;
            o_res_flags <= {r_res_full, r_res_new};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr       <= THR_RESET;
            r_lost      <= LOST_RESET;
            r_valid     <= '0;
            r_pre       <= '0;
            r_matched   <= '0;
            r_s0_v      <= 1'b0;
            r_s1_v      <= 1'b0;
            r_s2_v      <= 1'b0;
            r_s3_v      <= 1'b0;
            r_sw_v      <= 1'b0;
            r_found     <= 1'b0;
            r_next_id   <= ID_W'(1);
            o_res_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_MATCH_THRESHOLD: r_thr  <= i_cfg_data[THR_W-1:0];
                    REG_LOST_LIMIT:      r_lost <= i_cfg_data[LOST_W-1:0];
                    default: ;
                endcase
            end
            r_s0_v <= i_cmd.issue && r_valid[i_cmd.addr] && r_pre[i_cmd.addr] &&
                      !r_matched[i_cmd.addr];
            r_s1_v <= r_s0_v;
            r_s2_v <= r_s1_v && (r_s1_inter != '0);
            r_s3_v <= r_s2_v;
            r_sw_v <= i_cmd.sweep;
            if (i_cmd.load) begin
                r_found <= 1'b0;
            end else if (w_better) begin
                r_found <= 1'b1;
            end
            if (i_cmd.commit) begin
                if (w_match) begin
                    r_matched[r_best_slot] <= 1'b1;
                end else if (w_free_any) begin
                    r_valid[w_free_slot]   <= 1'b1;
                    r_pre[w_free_slot]     <= 1'b0;
                    r_matched[w_free_slot] <= 1'b0;
                    r_next_id <= (w_inc_id == '0) ? ID_W'(1) : w_inc_id;
                end
            end
            if (r_sw_v && w_stale) begin
                r_valid[r_sw_slot] <= 1'b0;
            end
            if (i_cmd.frame_start) begin
                r_pre     <= r_valid;
                r_matched <= '0;
            end
            if (i_cmd.out_load) begin
                o_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                o_res_valid <= 1'b0;
            end
        end
    end

    assign o_sts.frame_end = r_frame_end;
    assign o_sts.pipe_busy = r_s0_v | r_s1_v | r_s2_v | r_s3_v | r_sw_v;
    assign o_sts.out_free  = !o_res_valid || i_res_ready;

endmodule

// ----- rtl/giou_ctrl.sv -----
// Controller: sequences slot walk, match decision, result hand-off and stale sweep
module giou_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic            i_in_box,
    input  logic            i_in_end,
    output giou_pkg::t_cmd  o_cmd,
    input  giou_pkg::t_sts  i_sts
);
    import giou_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_WALK, S_DRAIN, S_THR, S_COMMIT, S_PUSH, S_SWEEP, S_SWEEP_END, S_FRAME
    } t_state;

    t_state            r_state;
    logic [SLOT_W-1:0] r_cnt;
    logic              r_phase;
    logic              w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd             = '0;
        o_cmd.addr        = r_cnt;
        o_cmd.load        = w_accept;
        o_cmd.issue       = (r_state == S_WALK) && !r_phase;
        o_cmd.thr         = (r_state == S_THR);
        o_cmd.commit      = (r_state == S_COMMIT);
        o_cmd.out_load    = (r_state == S_PUSH) && i_sts.out_free;
        o_cmd.sweep       = (r_state == S_SWEEP);
        o_cmd.frame_start = (r_state == S_FRAME);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_phase <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_cnt   <= '0;
                    r_phase <= 1'b0;
                    if (w_accept) begin
                        if (i_in_box) begin
                            r_state <= S_WALK;
                        end else if (i_in_end) begin
                            r_state <= S_SWEEP;
                        end
                    end
                end
                S_WALK: begin
                    r_phase <= !r_phase;
                    if (r_phase) begin
                        r_cnt <= r_cnt + 1'b1;
                        if (r_cnt == SLOT_W'(MAX_TRACKS - 1)) begin
                            r_state <= S_DRAIN;
                        end
                    end
                end
                S_DRAIN: begin
                    if (!i_sts.pipe_busy) begin
                        r_state <= S_THR;
                    end
                end
                S_THR:    r_state <= S_COMMIT;
                S_COMMIT: r_state <= S_PUSH;
                S_PUSH: begin
                    r_cnt <= '0;
                    if (i_sts.out_free) begin
                        r_state <= i_sts.frame_end ? S_SWEEP : S_IDLE;
                    end
                end
                S_SWEEP: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == SLOT_W'(MAX_TRACKS - 1)) begin
                        r_state <= S_SWEEP_END;
                    end
                end
                S_SWEEP_END: begin
                    if (!i_sts.pipe_busy) begin
                        r_state <= S_FRAME;
                    end
                end
                S_FRAME:  r_state <= S_IDLE;
                default:  r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- rtl/greedy_iou_track_association.sv -----
// Greedy IoU track association: top level joining controller and datapath
//
// Input stream carries one request per item: tdata holds the box edges and the
// frame number, tuser says whether a box is present, tlast ends the frame.
// A request with a box yields one result on the output stream (track id, new
// flag, table-full flag); a request without a box yields none.
// A box request walks the 32 track slots, drains the 4-stage IoU pipeline and
// then passes the threshold, commit and push states for the match decision
// and the result hand-off. A request that ends a frame adds a stale sweep of
// the 32 slots, one slot per cycle through the single read port of the track
// store. Only one request is in flight at a time: the input is ready again
// once the result sits in the output register and any sweep is done.
// A request with neither box nor frame end is taken without leaving the idle
// state.
// Reset clears all tracks, sets the next id to 1 and loads the register
// defaults (threshold 307, loss limit 30).
// When the receiver stalls, the result holds in the output register and the
// block waits before the sweep until the register is free.
module greedy_iou_track_association (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // box_left, box_top, box_right, box_bottom, frame_number
    input  logic [giou_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // has_box
    input  logic                                s_axis_tuser,
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // assigned_id
    output logic [giou_pkg::ID_W-1:0]           m_axis_tdata,
    // is_new, table_full
    output logic [1:0]                          m_axis_tuser,
    input  logic                                i_cfg_we,
    input  logic [giou_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [giou_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import giou_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    giou_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_in_box   (s_axis_tuser),
        .i_in_end   (s_axis_tlast),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    giou_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_data   (s_axis_tdata),
        .i_in_end    (s_axis_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_res_valid (m_axis_tvalid),
        .o_res_id    (m_axis_tdata),
        .o_res_flags (m_axis_tuser),
        .i_res_ready (m_axis_tready)
    );

`include "assert_macros.svh"

    `GIOU_ASSERT_TOP(a_zero_id_iff_full, m_axis_tvalid |-> ((m_axis_tdata == '0) == m_axis_tuser[1]), "id zero without full table")
    `GIOU_ASSERT_TOP(a_new_excludes_full, m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]), "new track on full table")
    `GIOU_ASSERT_TOP(a_one_request, (s_axis_tvalid && s_axis_tready && (s_axis_tuser || s_axis_tlast)) |=> !s_axis_tready, "request taken while busy")

endmodule

// ----- tb/testbench.sv -----
// Testbench for greedy_iou_track_association: directed and random frames checked against a predictor
module testbench;
    import giou_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE = 150;

    typedef struct {
        logic [ID_W-1:0] id;
        logic            is_new;
        logic            full;
    } t_track_result;

    class t_track_scoreboard;
        logic [THR_W-1:0]   thr;
        logic [LOST_W-1:0]  lost;
        bit                 valid [MAX_TRACKS];
        bit                 matched [MAX_TRACKS];
        bit                 preexist [MAX_TRACKS];
        logic [15:0]        box [MAX_TRACKS][4];
        logic [ID_W-1:0]    tid [MAX_TRACKS];
        logic [FRAME_W-1:0] seen [MAX_TRACKS];
        logic [ID_W-1:0]    next_id;
        t_track_result      pending_q [$];
        int                 errors;

        function new();
            thr = THR_RESET;
            lost = LOST_RESET;
            next_id = 1;
            errors = 0;
            foreach (valid[i]) begin
                valid[i] = 0;
                matched[i] = 0;
                preexist[i] = 0;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_MATCH_THRESHOLD) thr = val[THR_W-1:0];
            else lost = val[LOST_W-1:0];
        endfunction

        function logic [63:0] extent(logic [15:0] lo, logic [15:0] hi);
            return (hi > lo) ? 64'(hi - lo) : 64'd0;
        endfunction

        function void note_request(bit has_box, logic [15:0] b [4], logic [FRAME_W-1:0] fr,
                                   bit fend);
            bit             found;
            int             best;
            int             f;
            logic [127:0]   bi, bu, it, un, p1, p2;
            logic [63:0]    iw, ih;
            t_track_result  r;
            found = 0;
            best = 0;
            bi = 0;
            bu = 1;
            if (has_box) begin
                for (int s = 0; s < MAX_TRACKS; s++) begin
                    if (!valid[s] || !preexist[s] || matched[s]) continue;
                    iw = extent(b[0] > box[s][0] ? b[0] : box[s][0],
                                b[2] < box[s][2] ? b[2] : box[s][2]);
                    ih = extent(b[1] > box[s][1] ? b[1] : box[s][1],
                                b[3] < box[s][3] ? b[3] : box[s][3]);
                    it = iw * ih;
                    un = extent(b[0], b[2]) * extent(b[1], b[3])
                       + extent(box[s][0], box[s][2]) * extent(box[s][1], box[s][3]) - it;
                    if (it == 0) continue;
                    p1 = it * bu;
                    p2 = bi * un;
                    if (!found || p1 > p2 || (p1 == p2 && tid[s] < tid[best])) begin
                        found = 1;
                        best = s;
                        bi = it;
                        bu = un;
                    end
                end
                r = '{'0, 1'b0, 1'b0};
                if (found && bi * 1024 >= 128'(thr) * bu) begin
                    box[best] = b;
                    seen[best] = fr;
                    matched[best] = 1;
                    r.id = tid[best];
                end else begin
                    f = MAX_TRACKS;
                    for (int s = 0; s < MAX_TRACKS; s++)
                        if (!valid[s]) begin
                            f = s;
                            break;
                        end
                    if (f < MAX_TRACKS) begin
                        valid[f] = 1;
                        preexist[f] = 0;
                        matched[f] = 0;
                        box[f] = b;
                        tid[f] = next_id;
                        seen[f] = fr;
                        r.id = next_id;
                        r.is_new = 1;
                        next_id = next_id + 1;
                        if (next_id == 0) next_id = 1;
                    end else begin
                        r.full = 1;
                    end
                end
                pending_q.insert(pending_q.size(), r);
            end
            if (fend) begin
                for (int s = 0; s < MAX_TRACKS; s++) begin
                    if (valid[s] && fr > seen[s] && fr - seen[s] > 32'(lost)) valid[s] = 0;
                    preexist[s] = valid[s];
                    matched[s] = 0;
                end
            end
        endfunction

        function void check_result(logic [ID_W-1:0] id, logic is_new, logic full);
            t_track_result e;
            if (pending_q.size() == 0) begin
                $error("unexpected result id=%0d is_new=%0d table_full=%0d", id, is_new, full);
                errors++;
                return;
            end
            e = pending_q[0];
            pending_q.delete(0);
            if (id !== e.id) begin
                $error("assigned_id expected %0d actual %0d", e.id, id);
                errors++;
            end
            if (is_new !== e.is_new) begin
                $error("is_new expected %0d actual %0d", e.is_new, is_new);
                errors++;
            end
            if (full !== e.full) begin
                $error("table_full expected %0d actual %0d", e.full, full);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [ID_W-1:0]       m_axis_tdata;
    logic [1:0]            m_axis_tuser;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    t_track_scoreboard  sb;
    int                 cycles;
    int                 hold_cycles;
    int                 stall_mode;
    int                 burst_left;
    int                 sent;
    logic [FRAME_W-1:0] frame_no;

    greedy_iou_track_association dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // stall the result side on a changing pattern, or hold off for a long stretch
    initial begin
        m_axis_tready = 0;
        forever begin
            @(posedge i_clk);
            if (cycles % 300 == 0) stall_mode = $urandom_range(0, 2);
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_axis_tready <= 0;
            end else if (stall_mode == 0) m_axis_tready <= 1;
            else if (stall_mode == 1) m_axis_tready <= 1'($urandom_range(0, 1));
            else m_axis_tready <= ($urandom_range(0, 3) == 0);
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1]);

    task automatic send_request(bit has_box, logic [15:0] b [4], bit fend);
        if (burst_left == 0) begin
            if (s_axis_tvalid) begin
                s_axis_tvalid <= 0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_axis_tvalid <= 1;
        s_axis_tdata <= {frame_no, b[3], b[2], b[1], b[0]};
        s_axis_tuser <= has_box;
        s_axis_tlast <= fend;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(has_box, b, frame_no, fend);
        sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        burst_left = 0;
        do @(posedge i_clk); while (sb.pending_q.size() != 0 && cycles < CYCLE_LIMIT);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        drain();
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        sb.write_reg(idx, val);
    endtask

    function automatic void pick_box(output logic [15:0] b [4]);
        int          k;
        int          n;
        logic [15:0] w;
        k = $urandom_range(0, 99);
        n = 0;
        foreach (sb.valid[i]) if (sb.valid[i]) n++;
        if (k < 60 && n > 0) begin
            // reuse a live track with some jitter
            do k = $urandom_range(0, MAX_TRACKS - 1); while (!sb.valid[k]);
            b = sb.box[k];
            for (int e = 0; e < 4; e++) b[e] = 16'(b[e] + $urandom_range(0, 8) - 4);
            if ($urandom_range(0, 3) == 0) b[2] = 16'(b[2] + $urandom_range(0, 80));
        end else if (k < 88) begin
            b[0] = 16'($urandom_range(0, 2000));
            b[1] = 16'($urandom_range(0, 2000));
            w = 16'($urandom_range(1, 300));
            b[2] = b[0] + w;
            b[3] = 16'(b[1] + $urandom_range(1, 300));
        end else if (k < 94) begin
            for (int e = 0; e < 4; e++) b[e] = 16'($urandom());
        end else begin
            b[0] = 16'($urandom_range(100, 2000));
            b[1] = 16'($urandom_range(100, 2000));
            b[2] = 16'(b[0] - $urandom_range(1, 50));
            b[3] = 16'(b[1] + $urandom_range(0, 50));
        end
    endfunction

    task automatic send_frame(int boxes);
        logic [15:0] b [4];
        if (boxes == 0) begin
            b = '{default: 16'($urandom())};
            send_request(0, b, 1);
        end
        for (int i = 0; i < boxes; i++) begin
            pick_box(b);
            if ($urandom_range(0, 19) == 0) send_request(0, b, 0);
            send_request(1, b, i == boxes - 1);
        end
        case ($urandom_range(0, 19))
            0:       frame_no = $urandom();
            1:       frame_no = frame_no - $urandom_range(0, 3);
            2, 3:    frame_no = frame_no + $urandom_range(2, 70);
            default: frame_no = frame_no + 1;
        endcase
    endtask

    initial begin
        logic [15:0] b [4];
        logic [15:0] thr_set [6];
        logic [15:0] lost_set [6];
        thr_set = '{16'd2047, 16'd0, 16'd1024, 16'd307, 16'd512, 16'd900};
        lost_set = '{16'd65535, 16'd0, 16'd30, 16'd3, 16'd65535, 16'd10};
        sb = new();
        cycles = 0;
        hold_cycles = 0;
        stall_mode = 0;
        burst_left = 0;
        sent = 0;
        frame_no = 100;
        i_rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        s_axis_tuser = 0;
        s_axis_tlast = 0;
        i_cfg_we = 0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // edge boxes, twin tracks for a tie, exact rematch, inverted and empty items
        b = '{16'd0, 16'd0, 16'd0, 16'd0};
        send_request(1, b, 0);
        b = '{16'hffff, 16'hffff, 16'hffff, 16'hffff};
        send_request(1, b, 0);
        b = '{16'd0, 16'd0, 16'hffff, 16'hffff};
        send_request(1, b, 0);
        b = '{16'd10, 16'd10, 16'd50, 16'd60};
        send_request(1, b, 0);
        send_request(1, b, 1);
        frame_no = frame_no + 1;
        send_request(1, b, 0);
        send_request(1, b, 0);
        send_request(1, b, 0);
        b = '{16'd0, 16'd0, 16'hffff, 16'hffff};
        send_request(1, b, 0);
        b = '{16'd60, 16'd10, 16'd20, 16'd60};
        send_request(1, b, 0);
        send_request(0, b, 0);
        send_request(0, b, 1);
        frame_no = 32'hffff_fff0;
        b = '{16'd12, 16'd11, 16'd49, 16'd62};
        send_request(1, b, 1);
        frame_no = 32'hffff_ffff;
        send_request(0, b, 1);

        // the result side holds off while requests keep coming
        hold_cycles = 600;
        b = '{16'd5, 16'd5, 16'd9, 16'd9};
        for (int i = 0; i < 4; i++) send_request(1, b, 0);
        send_request(0, b, 1);
        frame_no = 0;
        drain();

        for (int p = 0; p < 7; p++) begin
            if (p < 6) begin
                write_reg(REG_MATCH_THRESHOLD, thr_set[p]);
                write_reg(REG_LOST_LIMIT, lost_set[p]);
            end else begin
                write_reg(REG_MATCH_THRESHOLD, CFG_DATA_W'($urandom_range(0, 2047)));
                write_reg(REG_LOST_LIMIT, CFG_DATA_W'($urandom_range(0, 65535)));
            end
            while (sent < 60 + (p + 1) * 145)
                send_frame(p == 0 ? $urandom_range(3, 12) : $urandom_range(0, 6));
        end
        drain();

        if (sb.pending_q.size() != 0) begin
            $error("%0d results never arrived", sb.pending_q.size());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end
endmodule
